>>> design/gfmi_pkg.sv
// shared constants, types and field arithmetic helpers for the gf(2^128) unit
package gfmi_pkg;

   localparam int FIELD_BITS  = 128;
   localparam int DIGIT_BITS  = 8;
   localparam int DIGIT_COUNT = FIELD_BITS / DIGIT_BITS;
   localparam int COUNT_W     = $clog2(DIGIT_COUNT);
   localparam int INV_ROUNDS  = FIELD_BITS - 1;
   localparam int ROUND_W     = $clog2(INV_ROUNDS);

   localparam logic [FIELD_BITS-1:0] REDUCE_POLY = FIELD_BITS'(8'h87);
   localparam logic [FIELD_BITS-1:0] FIELD_ONE   = FIELD_BITS'(1);

   localparam logic OP_MULTIPLY = 1'b0;
   localparam logic OP_INVERT   = 1'b1;

   typedef logic [FIELD_BITS-1:0] elem_type;

   // multiply by x and fold the carry back
   function automatic elem_type gf_times_x(input elem_type v);
      elem_type r;
      r = {v[FIELD_BITS-2:0], 1'b0};
      if (v[FIELD_BITS-1]) begin
         r = r ^ REDUCE_POLY;
      end
      return r;
   endfunction

   // fold a 256-bit carry-less product back into the field, two passes
   function automatic elem_type gf_reduce(input logic [2*FIELD_BITS-1:0] c);
      elem_type   h;
      elem_type   t;
      logic [6:0] g;
      h = c[2*FIELD_BITS-1:FIELD_BITS];
      t = c[FIELD_BITS-1:0] ^ h ^ (h << 1) ^ (h << 2) ^ (h << 7);
      g = h[FIELD_BITS-1:FIELD_BITS-7] ^ {5'b0, h[FIELD_BITS-1:FIELD_BITS-2]}
          ^ {6'b0, h[FIELD_BITS-1]};
      t = t ^ {{(FIELD_BITS-7){1'b0}}, g} ^ {{(FIELD_BITS-8){1'b0}}, g, 1'b0}
          ^ {{(FIELD_BITS-9){1'b0}}, g, 2'b0} ^ {{(FIELD_BITS-14){1'b0}}, g, 7'b0};
      return t;
   endfunction

   // squaring is linear: spread the bits apart, then reduce
   function automatic elem_type gf_square(input elem_type v);
      logic [2*FIELD_BITS-1:0] s;
      s = '0;
      for (int i = 0; i < FIELD_BITS; i++) begin
         s[2*i] = v[i];
      end
      return gf_reduce(s);
   endfunction

endpackage

>>> design/gf128_multiply_inverse.sv
// gf(2^128) multiply and inverse top level around one shared digit-serial multiplier
// a multiply runs one multiplier round; its result is registered in the output slot
// an inverse runs 127 multiplier rounds, one after another on the same multiplier
// the unit takes one item at a time, accepting new input only once the last result
// has gone to a free output slot; the multiplier takes 8 bits of b per cycle
// the squarer is combinational and advances the running square in the start state
// reset is synchronous: sequencer returns to idle and a pending result is dropped
module gf128_multiply_inverse (
   input  logic         clock,
   input  logic         reset,
   // input channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,   // a_low, a_high, b_low, b_high
   input  logic         req_tuser,   // opcode
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // result_low, result_high
);
   import gfmi_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;  // waiting for an input transfer
   localparam logic [1:0] ST_START  = 2'd1;  // kick off one multiplier round
   localparam logic [1:0] ST_WAIT   = 2'd2;  // multiplier running
   localparam logic [1:0] ST_FINISH = 2'd3;  // result waits for a free output slot

   logic [1:0]         state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;      // rounds completed so far
   logic [ROUND_W-1:0] last_ff, last_in;        // index of the final round
   elem_type           x_ff, x_in;              // running product / operand a
   elem_type           y_ff, y_in;              // running square / operand b
   logic               rsp_valid_ff, rsp_valid_in;
   elem_type           rsp_data_ff, rsp_data_in;

   logic               req_xfer;
   logic               mul_start;
   logic               mul_busy;
   logic               mul_done;
   elem_type           mul_product;
   elem_type           in_a;
   elem_type           in_b;

   assign in_a     = req_tdata[FIELD_BITS-1:0];
   assign in_b     = req_tdata[2*FIELD_BITS-1:FIELD_BITS];
   assign req_xfer = req_tvalid && req_tready;
   assign mul_start = (state_ff == ST_START);

   gfmi_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (x_ff),
      .op_b    (y_ff),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_product)
   );

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      last_in      = last_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // output register frees up on a result transfer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               round_in = '0;
               state_in = ST_START;
               if (req_tuser == OP_INVERT) begin
                  // acc = 1, sq = a^2; each round multiplies in the next square
                  x_in    = FIELD_ONE;
                  y_in    = gf_square(in_a);
                  last_in = ROUND_W'(INV_ROUNDS - 1);
               end else begin
                  x_in    = in_a;
                  y_in    = in_b;
                  last_in = '0;
               end
            end
         end
         ST_START: begin
            // multiplier latched the old square, so advance it now
            y_in     = gf_square(y_ff);
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_done) begin
               x_in = mul_product;
               if (round_ff == last_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  round_in = round_ff + ROUND_W'(1);
                  state_in = ST_START;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = x_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      round_ff <= last_ff) else $error("round counter ran past the final round");
   a_idle_mul_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mul_busy && !mul_done)
      else $error("multiplier active while sequencer idle");
   a_wait_holds_acc: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT && !mul_done |=> $stable(x_ff))
      else $error("running product changed mid round");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_START && round_ff == '0)
      else $error("input transfer did not start a round");

endmodule

>>> design/gfmi_mul.sv
// digit-serial gf(2^128) multiplier, most significant digit of b first
module gfmi_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  gfmi_pkg::elem_type op_a,
   input  gfmi_pkg::elem_type op_b,
   output logic               busy,
   output logic               done,
   output gfmi_pkg::elem_type product
);
   import gfmi_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   elem_type            a_ff, a_in;
   elem_type            b_ff, b_in;
   elem_type            acc_ff, acc_in;
   elem_type            step;

   // horner step over one digit of b
   always_comb begin
      step = acc_ff;
      for (int j = 0; j < DIGIT_BITS; j++) begin
         step = gf_times_x(step) ^ (b_ff[FIELD_BITS-1-j] ? a_ff : '0);
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         a_in     = op_a;
         b_in     = op_b;
         acc_in   = '0;
      end else if (busy_ff) begin
         acc_in   = step;
         b_in     = b_ff << DIGIT_BITS;
         count_in = count_ff + COUNT_W'(1);
         if (count_ff == COUNT_W'(DIGIT_COUNT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("multiplier restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_in |-> busy_ff && !start) else $error("done without a running product");

endmodule
